// File: hw/rtl/bflt_pkg.sv
// shared types and constants for the rgb565 bilinear filter pipeline
package bflt_pkg;

  // rgb565 field geometry
  localparam int unsigned RED_W     = 5;
  localparam int unsigned GREEN_W   = 6;
  localparam int unsigned BLUE_W    = 5;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned FRAC_W    = 4;
  localparam int unsigned WGT_W     = 9;
  localparam int unsigned WGT_SHIFT = 8;
  localparam int unsigned NUM_TAPS  = 4;

  // product and sum widths per channel
  localparam int unsigned RB_PROD_W = RED_W + WGT_W;
  localparam int unsigned G_PROD_W  = GREEN_W + WGT_W;
  localparam int unsigned SUM_W     = 16;

  // one in sixteenths
  localparam logic [FRAC_W:0] FRAC_ONE = 5'd16;

  // tap order: top-left, top-right, bottom-left, bottom-right
  localparam int unsigned TAP_TL = 0;
  localparam int unsigned TAP_TR = 1;
  localparam int unsigned TAP_BL = 2;
  localparam int unsigned TAP_BR = 3;

  // one pixel split into channels
  typedef struct packed {
    logic [RED_W-1:0]   r;
    logic [GREEN_W-1:0] g;
    logic [BLUE_W-1:0]  b;
  } rgb_t;

  // incoming word, fields decoded
  typedef struct packed {
    logic [NUM_TAPS-1:0][PIX_W-1:0] pix;
    logic [FRAC_W-1:0]              fx;
    logic [FRAC_W-1:0]              fy;
    logic                           last;
  } in_word_t;

  // after weight stage
  typedef struct packed {
    rgb_t [NUM_TAPS-1:0]            pix;
    logic [NUM_TAPS-1:0][WGT_W-1:0] wgt;
    logic                           last;
  } wgt_word_t;

  // after multiply stage
  typedef struct packed {
    logic [NUM_TAPS-1:0][RB_PROD_W-1:0] r;
    logic [NUM_TAPS-1:0][G_PROD_W-1:0]  g;
    logic [NUM_TAPS-1:0][RB_PROD_W-1:0] b;
    logic                               last;
  } prod_word_t;

  // result word
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } out_word_t;

endpackage

// File: hw/rtl/bflt_weight.sv
// stage 1: channel unpack and bilinear weight generation
module bflt_weight (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  bflt_pkg::in_word_t   up_word,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output bflt_pkg::wgt_word_t  dn_word
);
  import bflt_pkg::*;

  logic              valid_r;
  wgt_word_t         word_r;
  wgt_word_t         word_nxt;
  logic [FRAC_W:0]   ix;
  logic [FRAC_W:0]   iy;
  logic [FRAC_W:0]   fx_e;
  logic [FRAC_W:0]   fy_e;
  logic [2*FRAC_W+1:0] w_tl;
  logic [2*FRAC_W+1:0] w_tr;
  logic [2*FRAC_W+1:0] w_bl;
  logic [2*FRAC_W+1:0] w_br;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  // weights; they always sum to 256
  always_comb begin
    fx_e = {1'b0, up_word.fx};
    fy_e = {1'b0, up_word.fy};
    ix   = FRAC_ONE - fx_e;
    iy   = FRAC_ONE - fy_e;
    w_tl = {{(FRAC_W+1){1'b0}}, iy} * {{(FRAC_W+1){1'b0}}, ix};
    w_tr = {{(FRAC_W+1){1'b0}}, iy} * {{(FRAC_W+1){1'b0}}, fx_e};
    w_bl = {{(FRAC_W+1){1'b0}}, fy_e} * {{(FRAC_W+1){1'b0}}, ix};
    w_br = {{(FRAC_W+1){1'b0}}, fy_e} * {{(FRAC_W+1){1'b0}}, fx_e};
    word_nxt.wgt[TAP_TL] = w_tl[WGT_W-1:0];
    word_nxt.wgt[TAP_TR] = w_tr[WGT_W-1:0];
    word_nxt.wgt[TAP_BL] = w_bl[WGT_W-1:0];
    word_nxt.wgt[TAP_BR] = w_br[WGT_W-1:0];
    for (int i = 0; i < NUM_TAPS; i++) begin
      word_nxt.pix[i] = up_word.pix[i];
    end
    word_nxt.last = up_word.last;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

// File: hw/rtl/bflt_mul.sv
// stage 2: per-channel weight multiplies
module bflt_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  bflt_pkg::wgt_word_t   up_word,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output bflt_pkg::prod_word_t  dn_word
);
  import bflt_pkg::*;

  logic       valid_r;
  prod_word_t word_r;
  prod_word_t word_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  // twelve narrow products, one per tap and channel
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      word_nxt.r[i] = {{WGT_W{1'b0}}, up_word.pix[i].r} *
                      {{RED_W{1'b0}}, up_word.wgt[i]};
      word_nxt.g[i] = {{WGT_W{1'b0}}, up_word.pix[i].g} *
                      {{GREEN_W{1'b0}}, up_word.wgt[i]};
      word_nxt.b[i] = {{WGT_W{1'b0}}, up_word.pix[i].b} *
                      {{BLUE_W{1'b0}}, up_word.wgt[i]};
    end
    word_nxt.last = up_word.last;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

// File: hw/rtl/bflt_sum.sv
// stage 3: product sums, truncating shift and rgb565 repack
module bflt_sum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  bflt_pkg::prod_word_t  up_word,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output bflt_pkg::out_word_t   dn_word
);
  import bflt_pkg::*;

  logic             valid_r;
  out_word_t        word_r;
  out_word_t        word_nxt;
  logic [SUM_W-1:0] sum_r_ch;
  logic [SUM_W-1:0] sum_g_ch;
  logic [SUM_W-1:0] sum_b_ch;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  // weights sum to 256, so each sum is at most channel max times 256
  always_comb begin
    sum_r_ch = '0;
    sum_g_ch = '0;
    sum_b_ch = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      sum_r_ch = sum_r_ch + {{(SUM_W-RB_PROD_W){1'b0}}, up_word.r[i]};
      sum_g_ch = sum_g_ch + {{(SUM_W-G_PROD_W){1'b0}}, up_word.g[i]};
      sum_b_ch = sum_b_ch + {{(SUM_W-RB_PROD_W){1'b0}}, up_word.b[i]};
    end
    word_nxt.pix  = {sum_r_ch[WGT_SHIFT +: RED_W],
                     sum_g_ch[WGT_SHIFT +: GREEN_W],
                     sum_b_ch[WGT_SHIFT +: BLUE_W]};
    word_nxt.last = up_word.last;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

// File: hw/rtl/rgb565_bilinear_filter_unit.sv
// rgb565 bilinear filter: three-stage pipeline, one word per cycle
// an accepted word is registered in the weight, multiply and sum stages in
// turn, and out_tvalid rises once the sum stage holds it
// throughput: one word per cycle; each stage holds its word while stalled
// and fills bubbles, so in_tready falls only when all three stages are full
// reset: synchronous active-low rst_n clears the stage valid bits only
module rgb565_bilinear_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] top_left_pixel, [31:16] top_right_pixel, [47:32] bottom_left_pixel,
  // [63:48] bottom_right_pixel, [67:64] frac_x, [71:68] frac_y
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,   // span_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] filtered_pixel
  output logic [15:0] out_tdata,
  output logic        out_tlast   // span_last
);
  import bflt_pkg::*;

  in_word_t   in_word;
  wgt_word_t  wgt_word;
  prod_word_t prod_word;
  out_word_t  out_word;
  logic       wgt_valid;
  logic       wgt_ready;
  logic       prod_valid;
  logic       prod_ready;

  // unpack input word
  always_comb begin
    in_word.pix[TAP_TL] = in_tdata[15:0];
    in_word.pix[TAP_TR] = in_tdata[31:16];
    in_word.pix[TAP_BL] = in_tdata[47:32];
    in_word.pix[TAP_BR] = in_tdata[63:48];
    in_word.fx          = in_tdata[67:64];
    in_word.fy          = in_tdata[71:68];
    in_word.last        = in_tlast;
  end

  // weight stage
  bflt_weight u_weight (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_word  (in_word),
    .dn_valid (wgt_valid),
    .dn_ready (wgt_ready),
    .dn_word  (wgt_word)
  );

  // multiply stage
  bflt_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (wgt_valid),
    .up_ready (wgt_ready),
    .up_word  (wgt_word),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_word  (prod_word)
  );

  // sum and pack stage, doubles as output register
  bflt_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_word  (prod_word),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_word  (out_word)
  );

  assign out_tdata = out_word.pix;
  assign out_tlast = out_word.last;

endmodule
